// File: hdl/qte_pkg.sv
// Shared constants, widths and the arctangent table for the orientation block.
// No dependencies; qte_sqrt, qte_cordic and quaternion_to_euler_health use it by scoped names.
package qte_pkg;

	localparam int ZW = 30;

	localparam logic [63:0] Q60_ONE = 64'h1000_0000_0000_0000;
	localparam logic [63:0] Q59_ONE = 64'h0800_0000_0000_0000;

	localparam logic signed [ZW-1:0] DEG90  = 30'sd94371840;
	localparam logic signed [ZW-1:0] DEG180 = 30'sd188743680;

	localparam logic [15:0] LIM_WIDE   = 16'd18000;
	localparam logic [15:0] LIM_NARROW = 16'd9000;

	function automatic logic [25:0] atan_deg(input logic [4:0] idx);
		logic [25:0] v;
		unique case (idx)
			5'd0:  v = 26'd47185920;
			5'd1:  v = 26'd27855475;
			5'd2:  v = 26'd14718068;
			5'd3:  v = 26'd7471121;
			5'd4:  v = 26'd3750058;
			5'd5:  v = 26'd1876857;
			5'd6:  v = 26'd938658;
			5'd7:  v = 26'd469357;
			5'd8:  v = 26'd234682;
			5'd9:  v = 26'd117342;
			5'd10: v = 26'd58671;
			5'd11: v = 26'd29335;
			5'd12: v = 26'd14668;
			5'd13: v = 26'd7334;
			5'd14: v = 26'd3667;
			5'd15: v = 26'd1833;
			5'd16: v = 26'd917;
			5'd17: v = 26'd458;
			5'd18: v = 26'd229;
			5'd19: v = 26'd115;
			5'd20: v = 26'd57;
			5'd21: v = 26'd29;
			5'd22: v = 26'd14;
			5'd23: v = 26'd7;
			5'd24: v = 26'd4;
			5'd25: v = 26'd2;
			5'd26: v = 26'd1;
			default: v = 26'd0;
		endcase
		return v;
	endfunction

endpackage

// File: hdl/qte_mul.sv
// Bit-serial signed 32x32 multiplier: one multiplier bit per cycle, exact 64-bit product.
// Depends on nothing but the clock and reset.
module qte_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic               done,
	output logic signed [63:0] p
);

	typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mst_t;

	mst_t               st_q;
	logic [31:0]        mc_q;
	logic [64:0]        prod_q;
	logic               neg_q;
	logic [4:0]         cnt_q;
	logic               done_q;
	logic signed [63:0] p_q;

	logic [31:0] amag, bmag;
	logic [32:0] hi;

	always_comb begin
		amag = a[31] ? 32'(-a) : 32'(a);
		bmag = b[31] ? 32'(-b) : 32'(b);
		hi = prod_q[0] ? (prod_q[64:32] + {1'b0, mc_q}) : prod_q[64:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= M_IDLE;
			mc_q <= '0;
			prod_q <= '0;
			neg_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
			p_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				M_IDLE: begin
					if (start) begin
						mc_q <= amag;
						prod_q <= {33'd0, bmag};
						neg_q <= a[31] ^ b[31];
						cnt_q <= '0;
						st_q <= M_RUN;
					end
				end
				M_RUN: begin
					prod_q <= {1'b0, hi, prod_q[31:1]};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) st_q <= M_FIN;
				end
				M_FIN: begin
					p_q <= neg_q ? -signed'(prod_q[63:0]) : signed'(prod_q[63:0]);
					done_q <= 1'b1;
					st_q <= M_IDLE;
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign p = p_q;

endmodule

// File: hdl/qte_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle, for radicands up to 2^60.
// Uses qte_pkg for the starting weight.
module qte_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] n,
	output logic        done,
	output logic [31:0] root
);

	typedef enum logic {S_IDLE, S_RUN} sst_t;

	localparam int SQ_STEPS = 31;

	sst_t        st_q;
	logic [63:0] n_q, r_q, bit_q;
	logic [4:0]  cnt_q;
	logic        done_q;

	logic [63:0] trial;
	logic        ge;

	always_comb begin
		trial = r_q + bit_q;
		ge = n_q >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			n_q <= '0;
			r_q <= '0;
			bit_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						n_q <= n;
						r_q <= '0;
						bit_q <= qte_pkg::Q60_ONE;
						cnt_q <= '0;
						st_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (ge) begin
						n_q <= n_q - trial;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(SQ_STEPS - 1)) begin
						done_q <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];

endmodule

// File: hdl/qte_cordic.sv
// Vectoring CORDIC angle unit: serial normalize, one rotation per cycle, quadrant map,
// conversion to centidegrees with saturation. Uses qte_pkg for the angle table.
module qte_cordic #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               yneg,
	input  logic [63:0]        ay,
	input  logic               xneg,
	input  logic [63:0]        ax,
	input  logic               narrow,
	output logic               done,
	output logic signed [15:0] centi
);

	localparam int NIT = (STEPS < 32) ? STEPS : 32;
	localparam int ZW = qte_pkg::ZW;

	typedef enum logic [2:0] {C_IDLE, C_NORM, C_ITER, C_FIN1, C_FIN2} cst_t;

	cst_t                 st_q;
	logic [63:0]          ax_q, ay_q;
	logic                 xneg_q, yneg_q, narrow_q, zero_q;
	logic signed [33:0]   x_q, y_q;
	logic signed [ZW-1:0] z_q, ang_q;
	logic [4:0]           i_q;
	logic                 done_q;
	logic signed [15:0]   centi_q;

	logic signed [33:0]   dx, dy;
	logic signed [ZW-1:0] tab, zc, zq, ang;
	logic [ZW-1:0]        mag;
	logic [35:0]          scaled;
	logic [15:0]          cv, lim, cc;

	always_comb begin
		dx = x_q >>> i_q;
		dy = y_q >>> i_q;
		tab = signed'({4'b0, qte_pkg::atan_deg(i_q)});
		if (z_q < 0) zc = '0;
		else if (z_q > qte_pkg::DEG90) zc = qte_pkg::DEG90;
		else zc = z_q;
		zq = xneg_q ? (qte_pkg::DEG180 - zc) : zc;
		ang = zero_q ? '0 : (yneg_q ? -zq : zq);
		mag = ang_q[ZW-1] ? ZW'(-ang_q) : ZW'(ang_q);
		scaled = (36'(mag) << 6) + (36'(mag) << 5) + (36'(mag) << 2) + 36'h8_0000;
		cv = scaled[35:20];
		lim = narrow_q ? qte_pkg::LIM_NARROW : qte_pkg::LIM_WIDE;
		cc = (cv > lim) ? lim : cv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			ax_q <= '0;
			ay_q <= '0;
			xneg_q <= 1'b0;
			yneg_q <= 1'b0;
			narrow_q <= 1'b0;
			zero_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			ang_q <= '0;
			i_q <= '0;
			done_q <= 1'b0;
			centi_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				C_IDLE: begin
					if (start) begin
						ax_q <= ax;
						ay_q <= ay;
						xneg_q <= xneg;
						yneg_q <= yneg;
						narrow_q <= narrow;
						st_q <= C_NORM;
					end
				end
				C_NORM: begin
					priority if ((|ax_q[63:30]) || (|ay_q[63:30])) begin
						ax_q <= ax_q >> 1;
						ay_q <= ay_q >> 1;
					end else if (ax_q == 64'd0 && ay_q == 64'd0) begin
						zero_q <= 1'b1;
						st_q <= C_FIN1;
					end else begin
						zero_q <= 1'b0;
						x_q <= signed'({4'b0, ax_q[29:0]});
						y_q <= signed'({4'b0, ay_q[29:0]});
						z_q <= '0;
						i_q <= '0;
						st_q <= C_ITER;
					end
				end
				C_ITER: begin
					if (!y_q[33]) begin
						x_q <= x_q + dy;
						y_q <= y_q - dx;
						z_q <= z_q + tab;
					end else begin
						x_q <= x_q - dy;
						y_q <= y_q + dx;
						z_q <= z_q - tab;
					end
					i_q <= i_q + 5'd1;
					if (i_q == 5'(NIT - 1)) st_q <= C_FIN1;
				end
				C_FIN1: begin
					ang_q <= ang;
					st_q <= C_FIN2;
				end
				C_FIN2: begin
					centi_q <= ang_q[ZW-1] ? -signed'(cc) : signed'(cc);
					done_q <= 1'b1;
					st_q <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign centi = centi_q;

endmodule

// File: hdl/quaternion_to_euler_health.sv
// Sensor poll to roll/pitch/yaw with health tracking; sequencer over a bit-serial
// multiplier, a serial square root and a serial CORDIC. Uses qte_pkg, qte_mul, qte_sqrt, qte_cordic.
// A poll that yields no new angles goes from ST_IDLE straight to ST_OUT, which loads the result.
// A good sample runs three squares and a root for the scalar part, then for each of pitch,
// yaw and roll two serial products and a CORDIC run, roll also a square and a root before its CORDIC run;
// no root is taken for the scalar part when the vector norm reaches one.
// One poll in flight; a new poll is taken once the previous result sits in the output register.
// arst_n clears angles, health and time stamp, and loads the stale timeout with 100000.
module quaternion_to_euler_health #(
	parameter int CORDIC_STEPS = 16,
	parameter int TIME_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// nine_axis_x, nine_axis_y, nine_axis_z, six_axis_x, six_axis_y, six_axis_z, now_us
	input  logic [223:0] s_axis_tdata,
	// data_ready, fifo_status[2:0], has_quat9, has_quat6
	input  logic [5:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// updated, healthy, fifo_reset_request, roll_centideg[14:0], pitch_centideg, yaw_centideg
	output logic [55:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [23:0]  cfg_data
);

	localparam logic [2:0] FS_NODATA = 3'd2;
	localparam logic [2:0] FS_INCOMPLETE = 3'd3;
	localparam logic [2:0] FS_ERROR = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ_A, ST_SQ_B, ST_SQ_C, ST_W_PREP, ST_W_ROOT, ST_PR_1,
		ST_PR_2, ST_ARG, ST_T_SQ, ST_T_ROOT, ST_ANG, ST_OUT
	} st_t;

	typedef enum logic [1:0] {PH_PITCH, PH_YAW, PH_ROLL} phase_t;

	st_t                  state_q;
	phase_t               phase_q;
	logic                 issued_q;
	logic [23:0]          timeout_q;
	logic [TIME_BITS-1:0] last_q, now_q;
	logic                 health_q, upd_q, fifo_q;
	logic signed [14:0]   roll_q;
	logic signed [15:0]   pitch_q, yaw_q, pitch_new_q, yaw_new_q;
	logic signed [31:0]   a_q, b_q, c_q, w_q, t_q;
	logic [63:0]          aa_q, bb_q, acc_q, xs_q, sq_n_q;
	logic signed [63:0]   p1_q, yv_q;
	logic                 cor_yneg_q, cor_xneg_q;
	logic [63:0]          cor_ay_q, cor_ax_q;
	logic                 m_tvalid_q;
	logic [55:0]          m_tdata_q;

	logic                 s_acc;
	logic                 rdy, h9, h6;
	logic [2:0]           status;
	logic [TIME_BITS-1:0] elapsed;
	logic                 stale;
	logic signed [31:0]   mul_a, mul_b;
	logic                 mul_start, sq_start, cor_start;
	logic                 mul_done, sq_done, cor_done;
	logic signed [63:0]   mul_p;
	logic [31:0]          sq_root;
	logic signed [15:0]   cor_centi;
	logic signed [63:0]   hc, hs;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata = m_tdata_q;

	always_comb begin
		rdy = s_axis_tuser[0];
		status = s_axis_tuser[3:1];
		h9 = s_axis_tuser[4];
		h6 = s_axis_tuser[5];
		elapsed = s_axis_tdata[192 +: TIME_BITS] - last_q;
		stale = {{(33 - TIME_BITS){1'b0}}, elapsed} > {9'd0, timeout_q};

		mul_a = a_q;
		mul_b = a_q;
		unique case (state_q)
			ST_SQ_B: begin
				mul_a = b_q;
				mul_b = b_q;
			end
			ST_SQ_C: begin
				mul_a = c_q;
				mul_b = c_q;
			end
			ST_PR_1: begin
				mul_a = w_q;
				mul_b = (phase_q == PH_PITCH) ? a_q : ((phase_q == PH_YAW) ? c_q : b_q);
			end
			ST_PR_2: begin
				mul_a = (phase_q == PH_PITCH) ? b_q : ((phase_q == PH_YAW) ? a_q : c_q);
				mul_b = (phase_q == PH_PITCH) ? c_q : ((phase_q == PH_YAW) ? b_q : a_q);
			end
			ST_T_SQ: begin
				mul_a = t_q;
				mul_b = t_q;
			end
			default: begin
				mul_a = a_q;
				mul_b = a_q;
			end
		endcase

		mul_start = !issued_q && (state_q == ST_SQ_A || state_q == ST_SQ_B
			|| state_q == ST_SQ_C || state_q == ST_PR_1 || state_q == ST_PR_2
			|| state_q == ST_T_SQ);
		sq_start = !issued_q && (state_q == ST_W_ROOT || state_q == ST_T_ROOT);
		cor_start = !issued_q && (state_q == ST_ANG);

		if (yv_q > signed'(qte_pkg::Q59_ONE)) hc = signed'(qte_pkg::Q59_ONE);
		else if (yv_q < -signed'(qte_pkg::Q59_ONE)) hc = -signed'(qte_pkg::Q59_ONE);
		else hc = yv_q;
		hs = hc >>> 29;
	end

	qte_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	qte_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.n      (sq_n_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	qte_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.yneg   (cor_yneg_q),
		.ay     (cor_ay_q),
		.xneg   (cor_xneg_q),
		.ax     (cor_ax_q),
		.narrow (phase_q == PH_ROLL),
		.done   (cor_done),
		.centi  (cor_centi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_PITCH;
			issued_q <= 1'b0;
			timeout_q <= 24'd100000;
			last_q <= '0;
			now_q <= '0;
			health_q <= 1'b0;
			upd_q <= 1'b0;
			fifo_q <= 1'b0;
			roll_q <= '0;
			pitch_q <= '0;
			yaw_q <= '0;
			pitch_new_q <= '0;
			yaw_new_q <= '0;
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
			w_q <= '0;
			t_q <= '0;
			aa_q <= '0;
			bb_q <= '0;
			acc_q <= '0;
			xs_q <= '0;
			sq_n_q <= '0;
			p1_q <= '0;
			yv_q <= '0;
			cor_yneg_q <= 1'b0;
			cor_xneg_q <= 1'b0;
			cor_ay_q <= '0;
			cor_ax_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
		end else begin
			if (cfg_valid) timeout_q <= cfg_data;
			if (mul_start || sq_start || cor_start) issued_q <= 1'b1;
			if (m_tvalid_q && m_axis_tready) m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						upd_q <= 1'b0;
						fifo_q <= 1'b0;
						priority if (!rdy || status >= FS_ERROR) begin
							if (stale) health_q <= 1'b0;
							state_q <= ST_OUT;
						end else if (status == FS_NODATA) begin
							state_q <= ST_OUT;
						end else if (status == FS_INCOMPLETE) begin
							fifo_q <= 1'b1;
							state_q <= ST_OUT;
						end else if (h9 || h6) begin
							a_q <= h9 ? signed'(s_axis_tdata[31:0]) : signed'(s_axis_tdata[127:96]);
							b_q <= h9 ? signed'(s_axis_tdata[63:32]) : signed'(s_axis_tdata[159:128]);
							c_q <= h9 ? signed'(s_axis_tdata[95:64]) : signed'(s_axis_tdata[191:160]);
							now_q <= s_axis_tdata[192 +: TIME_BITS];
							state_q <= ST_SQ_A;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_SQ_A: begin
					if (mul_done) begin
						aa_q <= mul_p;
						issued_q <= 1'b0;
						state_q <= ST_SQ_B;
					end
				end
				ST_SQ_B: begin
					if (mul_done) begin
						bb_q <= mul_p;
						acc_q <= aa_q + mul_p;
						issued_q <= 1'b0;
						state_q <= ST_SQ_C;
					end
				end
				ST_SQ_C: begin
					if (mul_done) begin
						acc_q <= acc_q + mul_p;
						issued_q <= 1'b0;
						state_q <= ST_W_PREP;
					end
				end
				ST_W_PREP: begin
					if (acc_q < qte_pkg::Q60_ONE) begin
						sq_n_q <= qte_pkg::Q60_ONE - acc_q;
						state_q <= ST_W_ROOT;
					end else begin
						w_q <= '0;
						phase_q <= PH_PITCH;
						state_q <= ST_PR_1;
					end
				end
				ST_W_ROOT: begin
					if (sq_done) begin
						w_q <= signed'(sq_root);
						phase_q <= PH_PITCH;
						issued_q <= 1'b0;
						state_q <= ST_PR_1;
					end
				end
				ST_PR_1: begin
					if (mul_done) begin
						p1_q <= mul_p;
						issued_q <= 1'b0;
						state_q <= ST_PR_2;
					end
				end
				ST_PR_2: begin
					if (mul_done) begin
						yv_q <= (phase_q == PH_ROLL) ? (p1_q - mul_p) : (p1_q + mul_p);
						xs_q <= (phase_q == PH_YAW) ? (bb_q + (acc_q - aa_q - bb_q))
							: (aa_q + bb_q);
						issued_q <= 1'b0;
						state_q <= ST_ARG;
					end
				end
				ST_ARG: begin
					if (phase_q == PH_ROLL) begin
						t_q <= hs[31:0];
						state_q <= ST_T_SQ;
					end else begin
						cor_yneg_q <= yv_q[63];
						cor_ay_q <= yv_q[63] ? 64'(-yv_q) : 64'(yv_q);
						cor_xneg_q <= xs_q > qte_pkg::Q59_ONE;
						cor_ax_q <= (xs_q > qte_pkg::Q59_ONE) ? (xs_q - qte_pkg::Q59_ONE)
							: (qte_pkg::Q59_ONE - xs_q);
						state_q <= ST_ANG;
					end
				end
				ST_T_SQ: begin
					if (mul_done) begin
						sq_n_q <= qte_pkg::Q60_ONE - mul_p;
						issued_q <= 1'b0;
						state_q <= ST_T_ROOT;
					end
				end
				ST_T_ROOT: begin
					if (sq_done) begin
						cor_yneg_q <= t_q[31];
						cor_ay_q <= {32'd0, (t_q[31] ? 32'(-t_q) : 32'(t_q))};
						cor_xneg_q <= 1'b0;
						cor_ax_q <= {32'd0, sq_root};
						issued_q <= 1'b0;
						state_q <= ST_ANG;
					end
				end
				ST_ANG: begin
					if (cor_done) begin
						issued_q <= 1'b0;
						unique case (phase_q)
							PH_PITCH: begin
								pitch_new_q <= cor_centi;
								phase_q <= PH_YAW;
								state_q <= ST_PR_1;
							end
							PH_YAW: begin
								yaw_new_q <= cor_centi;
								phase_q <= PH_ROLL;
								state_q <= ST_PR_1;
							end
							default: begin
								roll_q <= 15'(-cor_centi);
								pitch_q <= pitch_new_q;
								yaw_q <= yaw_new_q;
								last_q <= now_q;
								health_q <= 1'b1;
								upd_q <= 1'b1;
								fifo_q <= 1'b0;
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_axis_tready) begin
						m_tdata_q <= {6'd0, yaw_q, pitch_q, roll_q, fifo_q, health_q, upd_q};
						m_tvalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		(roll_q >= -15'sd9000) && (roll_q <= 15'sd9000))
		else $error("roll out of range");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pitch_q >= -16'sd18000) && (pitch_q <= 16'sd18000)
		&& (yaw_q >= -16'sd18000) && (yaw_q <= 16'sd18000))
		else $error("pitch or yaw out of range");

	a_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ANG && cor_done && phase_q == PH_ROLL)
		|=> (health_q && upd_q && state_q == ST_OUT))
		else $error("good sample not committed");

	a_unit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done || sq_done || cor_done) |-> issued_q)
		else $error("unit finished without a start");

endmodule

// File: bench/tb.sv
// Testbench for quaternion_to_euler_health: stream driver, result monitor and a
// per-poll predictor of health, FIFO reset and CORDIC angles. Needs only the RTL.
module tb;

	typedef struct {
		bit        rdy;
		bit [2:0]  st;
		bit        h9;
		bit        h6;
		bit [31:0] q[6];
		bit [31:0] now;
	} poll_t;

	typedef struct {
		bit        upd;
		bit        hl;
		bit        frr;
		bit [14:0] roll;
		bit [15:0] pitch;
		bit [15:0] yaw;
	} pose_t;

	localparam longint unsigned Q30 = 64'd1 << 30;
	localparam longint unsigned Q59 = 64'd1 << 59;
	localparam longint unsigned Q60 = 64'd1 << 60;
	localparam longint CSTEPS = 16;
	localparam int LIMIT = 6000000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [223:0] s_axis_tdata;
	logic [5:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [55:0]  m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [23:0]  cfg_data;

	quaternion_to_euler_health dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	poll_t pending_polls[$];
	pose_t expected_poses[$];
	poll_t on_bus;
	bit    in_took;
	bit    calm;
	int    errors;
	int    results_seen;
	int    rx_hold;
	bit    hold_done;
	int    cycles;

	bit [31:0] p_last;
	bit        p_health;
	int        p_roll, p_pitch, p_yaw;
	bit [23:0] p_timeout;
	bit [31:0] clock_us;

	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint vector_angle(bit yneg, longint unsigned ay, bit xneg,
			longint unsigned ax);
		longint x, y, z, dx, dy;
		z = 0;
		while (ax >= Q30 || ay >= Q30) begin
			ax >>= 1;
			ay >>= 1;
		end
		if (ax == 0 && ay == 0) return 0;
		x = ax;
		y = ay;
		for (int i = 0; i < CSTEPS && i < 32; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x += dy; y -= dx; z += qte_pkg::atan_deg(i[4:0]);
			end else begin
				x -= dy; y += dx; z -= qte_pkg::atan_deg(i[4:0]);
			end
		end
		if (z < 0) z = 0;
		if (z > (longint'(90) << 20)) z = longint'(90) << 20;
		if (xneg) z = (longint'(180) << 20) - z;
		if (yneg) z = -z;
		return z;
	endfunction

	function automatic int centideg(longint a, longint lim);
		longint c;
		c = (mag(a) * 100 + (longint'(1) << 19)) >> 20;
		if (c > lim) c = lim;
		return int'(a < 0 ? -c : c);
	endfunction

	function automatic void solve_angles(longint a, longint b, longint c);
		longint unsigned aa, bb, cc, s3, xs, tm;
		longint w, yv, h, t;
		aa = a * a;
		bb = b * b;
		cc = c * c;
		s3 = aa + bb + cc;
		w = s3 < Q60 ? isqrt(Q60 - s3) : 0;
		yv = w * a + b * c;
		xs = aa + bb;
		p_pitch = centideg(vector_angle(yv < 0, mag(yv), xs > Q59,
			xs > Q59 ? xs - Q59 : Q59 - xs), 18000);
		yv = w * c + a * b;
		xs = bb + cc;
		p_yaw = centideg(vector_angle(yv < 0, mag(yv), xs > Q59,
			xs > Q59 ? xs - Q59 : Q59 - xs), 18000);
		h = w * b - c * a;
		if (h > longint'(Q59)) h = Q59;
		if (h < -longint'(Q59)) h = -longint'(Q59);
		t = h >>> 29;
		tm = mag(t);
		p_roll = centideg(-vector_angle(t < 0, tm, 1'b0, isqrt(Q60 - tm * tm)), 9000);
	endfunction

	function automatic pose_t predict_pose(poll_t p);
		pose_t r;
		bit stale;
		stale = (p.now - p_last) > {8'd0, p_timeout};
		r.upd = 0;
		r.frr = 0;
		if (!p.rdy || p.st >= 3'd4) begin
			if (stale) p_health = 0;
		end else if (p.st == 3'd3) begin
			r.frr = 1;
		end else if (p.st != 3'd2 && (p.h9 || p.h6)) begin
			if (p.h9)
				solve_angles(longint'($signed(p.q[0])), longint'($signed(p.q[1])),
					longint'($signed(p.q[2])));
			else
				solve_angles(longint'($signed(p.q[3])), longint'($signed(p.q[4])),
					longint'($signed(p.q[5])));
			p_last = p.now;
			p_health = 1;
			r.upd = 1;
		end
		r.hl = p_health;
		r.roll = p_roll[14:0];
		r.pitch = p_pitch[15:0];
		r.yaw = p_yaw[15:0];
		return r;
	endfunction

	function automatic bit [31:0] pick_part();
		case ($urandom_range(4))
			0: return $urandom;
			1: return {{3{1'($urandom_range(1))}}, 29'($urandom_range(32'h1fff_ffff))};
			2: return $urandom_range(1) ? 32'h4000_0000 : 32'hc000_0000;
			3: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return {{5{1'($urandom_range(1))}}, 27'($urandom)};
		endcase
	endfunction

	function automatic bit [31:0] next_time();
		case ($urandom_range(9))
			0: clock_us = $urandom;
			1, 2: clock_us += $urandom_range(400000);
			default: clock_us += $urandom_range(2000);
		endcase
		return clock_us;
	endfunction

	function automatic poll_t random_poll();
		poll_t p;
		for (int i = 0; i < 6; i++) p.q[i] = pick_part();
		p.now = next_time();
		p.rdy = 1;
		p.st = 3'($urandom_range(1));
		p.h9 = 1'($urandom_range(1));
		p.h6 = p.h9 ? 1'($urandom_range(1)) : 1'b1;
		if ($urandom_range(99) < 35) begin
			case ($urandom_range(4))
				0: p.rdy = 0;
				1: p.st = 3'd2;
				2: p.st = 3'd3;
				3: p.st = 3'($urandom_range(7, 4));
				default: {p.h9, p.h6} = 2'b00;
			endcase
		end
		return p;
	endfunction

	function automatic poll_t make_poll(bit rdy, bit [2:0] st, bit h9, bit h6,
			bit [31:0] x, bit [31:0] y, bit [31:0] z, bit [31:0] now);
		poll_t p;
		p.rdy = rdy; p.st = st; p.h9 = h9; p.h6 = h6;
		p.q[0] = x; p.q[1] = y; p.q[2] = z;
		p.q[3] = ~z; p.q[4] = x; p.q[5] = y;
		p.now = now;
		return p;
	endfunction

	task automatic drain();
		while (pending_polls.size() != 0 || s_axis_tvalid || expected_poses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(bit [23:0] v);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		p_timeout = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	always begin
		clk = 1; #5;
		clk = 0; #5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		in_took = arst_n && s_axis_tvalid && s_axis_tready;
		if (in_took) expected_poses.push_back(predict_pose(on_bus));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			pose_t e;
			results_seen++;
			if (expected_poses.size() == 0) begin
				$error("result with nothing expected: %h", m_axis_tdata);
				errors++;
			end else begin
				e = expected_poses.pop_front();
				if (m_axis_tdata[0] !== e.upd) begin
					$error("updated exp %0d got %0d", e.upd, m_axis_tdata[0]); errors++;
				end
				if (m_axis_tdata[1] !== e.hl) begin
					$error("healthy exp %0d got %0d", e.hl, m_axis_tdata[1]); errors++;
				end
				if (m_axis_tdata[2] !== e.frr) begin
					$error("fifo_reset_request exp %0d got %0d", e.frr, m_axis_tdata[2]);
					errors++;
				end
				if (m_axis_tdata[17:3] !== e.roll) begin
					$error("roll_centideg exp %0d got %0d", $signed(e.roll),
						$signed(m_axis_tdata[17:3]));
					errors++;
				end
				if (m_axis_tdata[33:18] !== e.pitch) begin
					$error("pitch_centideg exp %0d got %0d", $signed(e.pitch),
						$signed(m_axis_tdata[33:18]));
					errors++;
				end
				if (m_axis_tdata[49:34] !== e.yaw) begin
					$error("yaw_centideg exp %0d got %0d", $signed(e.yaw),
						$signed(m_axis_tdata[49:34]));
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_took)) begin
			if (pending_polls.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
				on_bus = pending_polls.pop_front();
				s_axis_tdata <= {on_bus.now, on_bus.q[5], on_bus.q[4], on_bus.q[3],
					on_bus.q[2], on_bus.q[1], on_bus.q[0]};
				s_axis_tuser <= {on_bus.h6, on_bus.h9, on_bus.st, on_bus.rdy};
				s_axis_tvalid <= 1;
			end else begin
				s_axis_tvalid <= 0;
			end
		end
	end

	always @(negedge clk) begin
		if (!hold_done && results_seen >= 400) begin
			hold_done = 1;
			rx_hold = 4000;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= arst_n && (calm || $urandom_range(99) >= 27);
		end
	end

	initial begin
		bit [23:0] settings[4];
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 0;
		cfg_valid = 0;
		cfg_data = '0;
		p_last = 0; p_health = 0; p_roll = 0; p_pitch = 0; p_yaw = 0;
		p_timeout = 24'd100000;
		clock_us = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		pending_polls.push_back(make_poll(0, 0, 1, 0, 0, 0, 0, 32'd50000));
		pending_polls.push_back(make_poll(0, 0, 1, 0, 0, 0, 0, 32'd100001));
		pending_polls.push_back(make_poll(1, 0, 1, 0, 0, 0, 0, 32'd100002));
		pending_polls.push_back(make_poll(1, 0, 0, 1, 32'h4000_0000, 0, 0, 32'd100010));
		pending_polls.push_back(make_poll(1, 1, 1, 1, 0, 32'h4000_0000, 0, 32'd100020));
		pending_polls.push_back(make_poll(1, 0, 1, 0, 0, 0, 32'h4000_0000, 32'd100030));
		pending_polls.push_back(make_poll(1, 0, 1, 0, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'd100040));
		pending_polls.push_back(make_poll(1, 0, 1, 0, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'd100050));
		pending_polls.push_back(make_poll(1, 0, 0, 1, 32'h2d41_3ccd, 32'hd2be_c333,
			32'h2d41_3ccd, 32'd100060));
		pending_polls.push_back(make_poll(1, 0, 1, 0, 32'h2d41_3ccc, 32'h2d41_3ccc, 0,
			32'd100070));
		pending_polls.push_back(make_poll(1, 0, 1, 0, 32'hc000_0000, 32'hc000_0000,
			32'h4000_0000, 32'd100080));
		pending_polls.push_back(make_poll(1, 2, 1, 1, 32'h1000_0000, 0, 0, 32'd900000));
		pending_polls.push_back(make_poll(1, 3, 1, 1, 32'h1000_0000, 0, 0, 32'd900001));
		pending_polls.push_back(make_poll(1, 7, 1, 1, 32'h1000_0000, 0, 0, 32'd900002));
		pending_polls.push_back(make_poll(1, 0, 0, 0, 32'h1000_0000, 0, 0, 32'd990000));
		pending_polls.push_back(make_poll(1, 4, 0, 0, 0, 0, 0, 32'd990001));
		pending_polls.push_back(make_poll(1, 1, 1, 0, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff));
		pending_polls.push_back(make_poll(0, 0, 0, 0, 0, 0, 0, 32'd5));
		pending_polls.push_back(make_poll(0, 5, 1, 1, 0, 0, 0, 32'd200000));
		pending_polls.push_back(make_poll(1, 6, 0, 1, 0, 0, 0, 32'd200001));
		drain();

		settings[0] = 24'd0;
		settings[1] = 24'hff_ffff;
		settings[2] = 24'd50;
		settings[3] = 24'($urandom_range(24'hff_ffff));
		for (int ph = 0; ph < 4; ph++) begin
			write_timeout(settings[ph]);
			calm = (ph == 2);
			for (int i = 0; i < 310; i++) pending_polls.push_back(random_poll());
			drain();
		end
		calm = 0;
		write_timeout(24'd100000);
		for (int i = 0; i < 20; i++) pending_polls.push_back(random_poll());
		drain();
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
